### sv/mes_pkg.sv
package mes_pkg;

  // point and orbit format: signed Q4.28
  localparam int unsigned Z_W        = 32;
  localparam int unsigned FRAC_BITS  = 28;
  // products are at most 2^62 before the shift, so a term needs 35 magnitude bits
  localparam int unsigned TERM_W     = 38;
  localparam int unsigned ITER_W     = 10;
  localparam int unsigned ITER_LIMIT = 1023;
  localparam int unsigned MUL_W      = 2 * Z_W;

  // log2 in Q.16, integer part up to 9 for 10-bit arguments
  localparam int unsigned LOG_BITS   = 16;
  localparam int unsigned LOG_E_W    = 4;
  localparam int unsigned LOG_W      = LOG_E_W + LOG_BITS;
  localparam int unsigned BITCNT_W   = $clog2(LOG_BITS);

  localparam int unsigned SHADE_W    = 8;
  localparam int unsigned DIVD_W     = LOG_W + SHADE_W;
  localparam int unsigned QCNT_W     = $clog2(SHADE_W);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_MAX_ITER   = 1'b0;
  localparam int unsigned MAX_ITER_RESET = 1000;

  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic [ITER_W-1:0]        iter_t;
  typedef logic [LOG_W-1:0]         log_t;
  typedef logic [SHADE_W-1:0]       shade_t;

  localparam term_t BOX_LIMIT  = term_t'(64'sd1 <<< (FRAC_BITS + 1));
  localparam shade_t SHADE_MAX = shade_t'(255);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_XYCAP,
    ST_STEP,
    ST_CLASS,
    ST_LM_SQ,
    ST_LM_UPD,
    ST_LK_SQ,
    ST_LK_UPD,
    ST_DIVCHK,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_XX,
    MUL_YY,
    MUL_XY,
    MUL_LOG
  } mul_sel_e;

  typedef enum logic {
    LS_M,
    LS_K
  } log_src_e;

  typedef enum logic [1:0] {
    SH_FULL,
    SH_ZERO,
    SH_DIV
  } shade_src_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic       cap_xx;
    logic       cap_yy;
    logic       cap_xy;
    logic       step;
    logic       log_init;
    log_src_e   log_src;
    logic       log_step;
    logic       save_lm;
    logic       save_lk;
    logic       div_start;
    logic       shade_set;
    shade_src_e shade_src;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic step_end;
    logic trivial;
    logic log_bad;
    logic div_done;
  } stat_t;

endpackage

### sv/mes_div.sv
module mes_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mes_pkg::DIVD_W-1:0]    dividend_i,
  input  mes_pkg::log_t                 divisor_i,
  output logic                          done_o,
  output mes_pkg::shade_t               quot_o
);

  logic [mes_pkg::DIVD_W-1:0] rem_q, rem_d;
  mes_pkg::log_t              div_q, div_d;
  mes_pkg::shade_t            quot_q, quot_d;
  logic [mes_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [mes_pkg::DIVD_W:0]   trial;

  // restoring division, one quotient bit a cycle, msb first
  assign trial = {1'b0, rem_q} -
                 {1'b0, (mes_pkg::DIVD_W'(div_q) << cnt_q)};

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = dividend_i;
      div_d  = divisor_i;
      quot_d = '0;
      cnt_d  = mes_pkg::QCNT_W'(mes_pkg::SHADE_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quot_d = {quot_q[mes_pkg::SHADE_W-2:0], ~trial[mes_pkg::DIVD_W]};
      if (!trial[mes_pkg::DIVD_W]) begin
        rem_d = trial[mes_pkg::DIVD_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  // a finished division leaves a remainder below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && div_q != '0) |-> (rem_q < mes_pkg::DIVD_W'(div_q)))
    else $error("division remainder not below divisor");

endmodule

### sv/mes_dp.sv
module mes_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mes_pkg::cmd_t   cmd_i,
  output mes_pkg::stat_t  stat_o,
  input  mes_pkg::iter_t  max_iter_i,
  input  mes_pkg::z_t     c_real_i,
  input  mes_pkg::z_t     c_imag_i,
  output mes_pkg::iter_t  escape_count_o,
  output mes_pkg::shade_t shade_o
);

  mes_pkg::z_t   cx_q, cy_q, zx_q, zy_q;
  mes_pkg::term_t xx_q, yy_q, xy_q;
  logic [mes_pkg::MUL_W-1:0] prod_q;
  mes_pkg::iter_t k_q, m_q, count_q;
  logic [mes_pkg::Z_W-1:0]      x_q;
  logic [mes_pkg::LOG_E_W-1:0]  e_q;
  logic [mes_pkg::LOG_BITS-1:0] frac_q;
  mes_pkg::log_t   lm_q, lk_q;
  mes_pkg::shade_t shade_q;
  mes_pkg::iter_t  esc_out_q;
  mes_pkg::shade_t shade_out_q;

  mes_pkg::iter_t m_lim;
  logic [mes_pkg::Z_W-1:0] zx_mag, zy_mag, mul_a, mul_b;
  logic [mes_pkg::Z_W:0]   sq_top;
  logic                    log_bit;
  logic [mes_pkg::Z_W-1:0] x_sq;
  logic [mes_pkg::LOG_BITS-1:0] frac_next;
  mes_pkg::iter_t          log_n;
  logic [mes_pkg::LOG_E_W-1:0] e_init;
  logic [mes_pkg::Z_W-1:0] x_init;
  mes_pkg::term_t nx, ny, xy_mag;
  logic escaped, last;
  mes_pkg::log_t lg_diff;
  logic [mes_pkg::DIVD_W-1:0] dividend;
  logic div_done;
  mes_pkg::shade_t quot;

  assign m_lim = (max_iter_i > mes_pkg::iter_t'(mes_pkg::ITER_LIMIT)) ?
                 mes_pkg::iter_t'(mes_pkg::ITER_LIMIT) : max_iter_i;

  assign zx_mag = zx_q[mes_pkg::Z_W-1] ? unsigned'(-zx_q) : unsigned'(zx_q);
  assign zy_mag = zy_q[mes_pkg::Z_W-1] ? unsigned'(-zy_q) : unsigned'(zy_q);

  // one shared 32x32 multiplier for the orbit and the log squarings
  always_comb begin
    case (cmd_i.mul_sel)
      mes_pkg::MUL_XX: begin
        mul_a = zx_mag;
        mul_b = zx_mag;
      end
      mes_pkg::MUL_YY: begin
        mul_a = zy_mag;
        mul_b = zy_mag;
      end
      mes_pkg::MUL_XY: begin
        mul_a = zx_mag;
        mul_b = zy_mag;
      end
      default: begin
        mul_a = x_q;
        mul_b = x_q;
      end
    endcase
  end

  // mantissa square back in Q1.31, renormalised when it reaches 2.0
  assign sq_top    = prod_q[mes_pkg::MUL_W-1:mes_pkg::Z_W-1];
  assign log_bit   = sq_top[mes_pkg::Z_W];
  assign x_sq      = log_bit ? sq_top[mes_pkg::Z_W:1] : sq_top[mes_pkg::Z_W-1:0];
  assign frac_next = {frac_q[mes_pkg::LOG_BITS-2:0], log_bit};

  assign log_n = (cmd_i.log_src == mes_pkg::LS_M) ? m_q : count_q;

  always_comb begin
    e_init = '0;
    for (int i = 0; i < int'(mes_pkg::ITER_W); i++) begin
      if (log_n[i]) begin
        e_init = mes_pkg::LOG_E_W'(i);
      end
    end
  end

  assign x_init = mes_pkg::Z_W'(log_n) << (5'(mes_pkg::Z_W - 1) - 5'(e_init));

  assign xy_mag = mes_pkg::term_t'(prod_q >> (mes_pkg::FRAC_BITS - 1));

  assign nx = xx_q - yy_q + mes_pkg::term_t'(cx_q);
  assign ny = xy_q + mes_pkg::term_t'(cy_q);

  // box test, both bounds inclusive
  assign escaped = (nx < -mes_pkg::BOX_LIMIT) || (nx > mes_pkg::BOX_LIMIT) ||
                   (ny < -mes_pkg::BOX_LIMIT) || (ny > mes_pkg::BOX_LIMIT);
  assign last    = (k_q == m_q);

  // 255 * (lm - lk) as a shift and subtract
  assign lg_diff  = lm_q - lk_q;
  assign dividend = {lg_diff, {mes_pkg::SHADE_W{1'b0}}} - mes_pkg::DIVD_W'(lg_diff);

  mes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (lm_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mes_pkg::MUL_W'(mul_a) * mes_pkg::MUL_W'(mul_b);
    end
    if (cmd_i.cap_xx) begin
      xx_q <= mes_pkg::term_t'(prod_q >> mes_pkg::FRAC_BITS);
    end
    if (cmd_i.cap_yy) begin
      yy_q <= mes_pkg::term_t'(prod_q >> mes_pkg::FRAC_BITS);
    end
    if (cmd_i.cap_xy) begin
      xy_q <= (zx_q[mes_pkg::Z_W-1] ^ zy_q[mes_pkg::Z_W-1]) ? -xy_mag : xy_mag;
    end

    if (cmd_i.load) begin
      cx_q    <= c_real_i;
      cy_q    <= c_imag_i;
      zx_q    <= c_real_i;
      zy_q    <= c_imag_i;
      k_q     <= mes_pkg::iter_t'(1);
      m_q     <= m_lim;
      count_q <= '0;
    end else if (cmd_i.step) begin
      if (escaped) begin
        count_q <= k_q;
      end else if (!last) begin
        zx_q <= mes_pkg::z_t'(nx);
        zy_q <= mes_pkg::z_t'(ny);
        k_q  <= k_q + 1'b1;
      end
    end

    if (cmd_i.log_init) begin
      x_q    <= x_init;
      e_q    <= e_init;
      frac_q <= '0;
    end else if (cmd_i.log_step) begin
      x_q    <= x_sq;
      frac_q <= frac_next;
    end
    if (cmd_i.save_lm) begin
      lm_q <= {e_q, frac_next};
    end
    if (cmd_i.save_lk) begin
      lk_q <= {e_q, frac_next};
    end

    if (cmd_i.shade_set) begin
      case (cmd_i.shade_src)
        mes_pkg::SH_FULL: shade_q <= mes_pkg::SHADE_MAX;
        mes_pkg::SH_DIV:  shade_q <= quot;
        default:          shade_q <= '0;
      endcase
    end

    if (cmd_i.out_load) begin
      esc_out_q   <= count_q;
      shade_out_q <= shade_q;
    end
  end

  assign stat_o.m_zero   = (m_lim == '0);
  assign stat_o.step_end = escaped || last;
  assign stat_o.trivial  = (count_q == '0) || count_q[0];
  assign stat_o.log_bad  = (lk_q > lm_q) || (lm_q == '0);
  assign stat_o.div_done = div_done;

  assign escape_count_o = esc_out_q;
  assign shade_o        = shade_out_q;

  // odd or zero counts always come out full white
  a_trivial_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && ((count_q == '0) || count_q[0])) |=>
      (shade_out_q == mes_pkg::SHADE_MAX))
    else $error("odd or zero count without full shade");

  // an orbit that keeps going stays inside the box
  a_orbit_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !escaped && !last) |=>
      ((mes_pkg::term_t'(zx_q) <= mes_pkg::BOX_LIMIT) &&
       (mes_pkg::term_t'(zx_q) >= -mes_pkg::BOX_LIMIT) &&
       (mes_pkg::term_t'(zy_q) <= mes_pkg::BOX_LIMIT) &&
       (mes_pkg::term_t'(zy_q) >= -mes_pkg::BOX_LIMIT)))
    else $error("orbit left the box without escaping");

endmodule

### sv/mes_ctrl.sv
module mes_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  mes_pkg::stat_t stat_i,
  output mes_pkg::cmd_t  cmd_o
);

  mes_pkg::state_e state_q, state_d;
  logic [mes_pkg::BITCNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic out_valid_q, out_valid_d;
  logic last_bit;

  assign last_bit = (bit_cnt_q == mes_pkg::BITCNT_W'(mes_pkg::LOG_BITS - 1));

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    cmd_o     = '0;
    unique case (state_q)
      mes_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.m_zero ? mes_pkg::ST_CLASS : mes_pkg::ST_XX;
        end
      end
      mes_pkg::ST_XX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mes_pkg::MUL_XX;
        state_d       = mes_pkg::ST_YY;
      end
      mes_pkg::ST_YY: begin
        cmd_o.cap_xx  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mes_pkg::MUL_YY;
        state_d       = mes_pkg::ST_XY;
      end
      mes_pkg::ST_XY: begin
        cmd_o.cap_yy  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mes_pkg::MUL_XY;
        state_d       = mes_pkg::ST_XYCAP;
      end
      mes_pkg::ST_XYCAP: begin
        cmd_o.cap_xy = 1'b1;
        state_d      = mes_pkg::ST_STEP;
      end
      mes_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = stat_i.step_end ? mes_pkg::ST_CLASS : mes_pkg::ST_XX;
      end
      mes_pkg::ST_CLASS: begin
        if (stat_i.trivial) begin
          cmd_o.shade_set = 1'b1;
          cmd_o.shade_src = mes_pkg::SH_FULL;
          state_d         = mes_pkg::ST_OUT;
        end else begin
          cmd_o.log_init = 1'b1;
          cmd_o.log_src  = mes_pkg::LS_M;
          bit_cnt_d      = '0;
          state_d        = mes_pkg::ST_LM_SQ;
        end
      end
      mes_pkg::ST_LM_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mes_pkg::MUL_LOG;
        state_d       = mes_pkg::ST_LM_UPD;
      end
      mes_pkg::ST_LK_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mes_pkg::MUL_LOG;
        state_d       = mes_pkg::ST_LK_UPD;
      end
      mes_pkg::ST_LM_UPD: begin
        cmd_o.mul_sel = mes_pkg::MUL_LOG;
        if (last_bit) begin
          // store log of the bound and start on the count
          cmd_o.save_lm  = 1'b1;
          cmd_o.log_init = 1'b1;
          cmd_o.log_src  = mes_pkg::LS_K;
          bit_cnt_d      = '0;
          state_d        = mes_pkg::ST_LK_SQ;
        end else begin
          cmd_o.log_step = 1'b1;
          bit_cnt_d      = bit_cnt_q + 1'b1;
          state_d        = mes_pkg::ST_LM_SQ;
        end
      end
      mes_pkg::ST_LK_UPD: begin
        cmd_o.mul_sel = mes_pkg::MUL_LOG;
        cmd_o.log_src = mes_pkg::LS_K;
        if (last_bit) begin
          cmd_o.save_lk = 1'b1;
          state_d       = mes_pkg::ST_DIVCHK;
        end else begin
          cmd_o.log_step = 1'b1;
          bit_cnt_d      = bit_cnt_q + 1'b1;
          state_d        = mes_pkg::ST_LK_SQ;
        end
      end
      mes_pkg::ST_DIVCHK: begin
        if (stat_i.log_bad) begin
          cmd_o.shade_set = 1'b1;
          cmd_o.shade_src = mes_pkg::SH_ZERO;
          state_d         = mes_pkg::ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = mes_pkg::ST_DIV;
        end
      end
      mes_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.shade_set = 1'b1;
          cmd_o.shade_src = mes_pkg::SH_DIV;
          state_d         = mes_pkg::ST_OUT;
        end
      end
      mes_pkg::ST_OUT: begin
        // output register free, or emptied by a transfer this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = mes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mes_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mes_pkg::ST_IDLE;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != mes_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // every log starts from bit zero of the fraction
  a_log_cnt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mes_pkg::ST_CLASS && state_d == mes_pkg::ST_LM_SQ) |=>
      (bit_cnt_q == '0))
    else $error("log bit counter not cleared");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && out_valid_q) |-> !out_stall_i)
    else $error("pending result overwritten");

endmodule

### sv/mandelbrot_escape_shader_core.sv
// Mandelbrot escape-time shader. Each transfer on the input brings one point c
// (signed Q4.28); the block iterates z = z*z + c from z = c and returns the first
// step at which either part of z leaves [-2, 2] (0 if none within max_iterations),
// plus a gray shade: 255 for an odd or zero count, else 255*(1 - log2 k/log2 m) from
// a fixed-point log with 16 fraction bits. All products go through one 32x32
// multiplier, so each iteration step runs through the states XX, YY, XY, XYCAP
// and STEP in turn. An item runs the orbit (k = escape step, or max_iterations
// for a point that stays), then either sets the full shade for an odd or zero
// count, or works out the two logs (a squaring and an update per fraction bit)
// and the shade division; it then hands the result to the output register,
// waiting for a full one to drain. One point is worked on at a time; the next is
// taken while the previous result still waits in the output register.
// max_iterations sits at byte address 0 of the register port and resets to 1000.
module mandelbrot_escape_shader_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mes_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mes_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mes_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [mes_pkg::Z_W-1:0]     c_real_i,
  input  logic signed [mes_pkg::Z_W-1:0]     c_imag_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mes_pkg::ITER_W-1:0]         escape_count_o,
  output logic [mes_pkg::SHADE_W-1:0]        shade_o
);

  mes_pkg::iter_t max_iter_q, max_iter_d;
  logic           reg_hit;
  mes_pkg::cmd_t  cmd;
  mes_pkg::stat_t stat;

  assign reg_hit = (paddr[mes_pkg::CFG_ADDR_W-1:2] == mes_pkg::REG_MAX_ITER);

  always_comb begin
    max_iter_d = max_iter_q;
    if (psel && penable && pwrite && reg_hit) begin
      max_iter_d = pwdata[mes_pkg::ITER_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mes_pkg::iter_t'(mes_pkg::MAX_ITER_RESET);
    end else begin
      max_iter_q <= max_iter_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_hit ? mes_pkg::CFG_DATA_W'(max_iter_q) : '0;

  mes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mes_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .max_iter_i     (max_iter_q),
    .c_real_i       (c_real_i),
    .c_imag_i       (c_imag_i),
    .escape_count_o (escape_count_o),
    .shade_o        (shade_o)
  );

endmodule
